@@ rtl/tea_pkg.sv @@
// Shared constants, types and round function for the TEA cipher pipeline.
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

	// Golden-ratio round constant
	localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

	// Default number of cipher cycles (two half-rounds each)
	localparam int TEA_ROUNDS = 32;

	// Key register count and reset values
	localparam int TEA_KEY_WORDS = 4;
	localparam int TEA_KEY_IDX_W = $clog2(TEA_KEY_WORDS);

	localparam logic [TEA_KEY_IDX_W-1:0] KEY_IDX_W0 = TEA_KEY_IDX_W'(0);
	localparam logic [TEA_KEY_IDX_W-1:0] KEY_IDX_W1 = TEA_KEY_IDX_W'(1);
	localparam logic [TEA_KEY_IDX_W-1:0] KEY_IDX_W2 = TEA_KEY_IDX_W'(2);
	localparam logic [TEA_KEY_IDX_W-1:0] KEY_IDX_W3 = TEA_KEY_IDX_W'(3);

	localparam logic [31:0] KEY_RST_W0 = 32'd1;
	localparam logic [31:0] KEY_RST_W1 = 32'd2;
	localparam logic [31:0] KEY_RST_W2 = 32'd3;
	localparam logic [31:0] KEY_RST_W3 = 32'd4;

	// Request type codes
	localparam logic REQ_ENCRYPT = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	typedef logic [TEA_KEY_WORDS-1:0][31:0] tea_key_t;

	// Block in flight through the chain
	typedef struct packed {
		logic        dec;
		logic [31:0] a;
		logic [31:0] b;
	} tea_data_t;

	// Forward half of a link between neighbouring stages
	typedef struct packed {
		logic      valid;
		tea_data_t data;
	} tea_link_t;

	// TEA mixing term: ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb)
	function automatic logic [31:0] tea_mix(
		input logic [31:0] x,
		input logic [31:0] sum,
		input logic [31:0] ka,
		input logic [31:0] kb
	);
		return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
	endfunction

endpackage

`default_nettype wire

@@ rtl/tea_req_if.sv @@
// Request channel: operation and 64-bit block as two words.
`timescale 1ns / 1ps
`default_nettype none

interface tea_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] block_first;
	logic [31:0] block_second;

	modport source (output valid, output req_type, output block_first,
		output block_second, input ready);
	modport sink (input valid, input req_type, input block_first,
		input block_second, output ready);
endinterface

`default_nettype wire

@@ rtl/tea_rsp_if.sv @@
// Response channel: transformed 64-bit block as two words.
`timescale 1ns / 1ps
`default_nettype none

interface tea_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_first;
	logic [31:0] out_second;

	modport source (output valid, output out_first, output out_second, input ready);
	modport sink (input valid, input out_first, input out_second, output ready);
endinterface

`default_nettype wire

@@ rtl/tea_half.sv @@
// One Feistel half-round stage with its own handshake register.
`timescale 1ns / 1ps
`default_nettype none

module tea_half
	import tea_pkg::*;
#(
	parameter logic        SECOND  = 1'b0,
	parameter logic [31:0] SUM_ENC = TEA_DELTA,
	parameter logic [31:0] SUM_DEC = TEA_DELTA
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tea_key_t  key,
	input  wire tea_link_t up_link,
	output logic           up_ready,
	output tea_link_t      dn_link,
	input  wire logic      dn_ready
);

	logic        valid_s1;
	tea_data_t   data_s1;
	logic        tgt_a;
	logic [31:0] x;
	logic [31:0] ka;
	logic [31:0] kb;
	logic [31:0] sum;
	logic [31:0] mix;
	logic [31:0] tgt;
	logic [31:0] tgt_new;
	tea_data_t   nxt;
	logic        adv;

	// Stage moves when empty or when the next one takes its transaction
	assign adv      = !valid_s1 || dn_ready;
	assign up_ready = adv;

	// Encrypt updates a first then b; decrypt undoes b first then a
	always_comb begin
		tgt_a   = (up_link.data.dec == SECOND);
		x       = tgt_a ? up_link.data.b : up_link.data.a;
		ka      = tgt_a ? key[KEY_IDX_W0] : key[KEY_IDX_W2];
		kb      = tgt_a ? key[KEY_IDX_W1] : key[KEY_IDX_W3];
		sum     = (up_link.data.dec == REQ_DECRYPT) ? SUM_DEC : SUM_ENC;
		mix     = tea_mix(x, sum, ka, kb);
		tgt     = tgt_a ? up_link.data.a : up_link.data.b;
		tgt_new = (up_link.data.dec == REQ_DECRYPT) ? tgt - mix : tgt + mix;
		nxt     = up_link.data;
		if (tgt_a) begin
			nxt.a = tgt_new;
		end else begin
			nxt.b = tgt_new;
		end
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= up_link.valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv && up_link.valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_link = {valid_s1, data_s1};

endmodule

`default_nettype wire

@@ rtl/tea_cell.sv @@
// One TEA cycle: two half-round stages with the sums for this position.
`timescale 1ns / 1ps
`default_nettype none

module tea_cell
	import tea_pkg::*;
#(
	parameter int ROUND_COUNT = TEA_ROUNDS,
	parameter int ROUND_IDX   = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tea_key_t  key,
	input  wire tea_link_t up_link,
	output logic           up_ready,
	output tea_link_t      dn_link,
	input  wire logic      dn_ready
);

	// Encrypt sum after n+1 additions; decrypt sum for the mirrored cycle
	localparam logic [31:0] SUM_ENC = 32'(64'(TEA_DELTA) * 64'(ROUND_IDX + 1));
	localparam logic [31:0] SUM_DEC = 32'(64'(TEA_DELTA) * 64'(ROUND_COUNT - ROUND_IDX));

	tea_link_t mid_link;
	logic      mid_ready;

	tea_half #(
		.SECOND  (1'b0),
		.SUM_ENC (SUM_ENC),
		.SUM_DEC (SUM_DEC)
	) u_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key),
		.up_link  (up_link),
		.up_ready (up_ready),
		.dn_link  (mid_link),
		.dn_ready (mid_ready)
	);

	tea_half #(
		.SECOND  (1'b1),
		.SUM_ENC (SUM_ENC),
		.SUM_DEC (SUM_DEC)
	) u_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key),
		.up_link  (mid_link),
		.up_ready (mid_ready),
		.dn_link  (dn_link),
		.dn_ready (dn_ready)
	);

endmodule

`default_nettype wire

@@ rtl/tea_block_cipher_core.sv @@
// TEA block cipher core: key registers and a chain of round cells.
//
// Usage:
//   req carries req_type (0 encrypt, 1 decrypt) and a 64-bit block as
//   block_first/block_second; rsp returns out_first/out_second, one
//   transaction per request, in request order.
//   The key is four 32-bit words written through cfg_we/cfg_idx/cfg_data;
//   write only while no block is in flight.
//   A block travels from request accept to response valid through every
//   stage of the chain in order: each cell holds one cycle of the cipher
//   as two half-round stages, one register each.
//   Throughput is one block per clock while rsp is ready; each stage holds
//   its own block.
//   Reset clears every stage's valid bit and loads the key 1, 2, 3, 4.
//   When rsp stalls, the last stage holds; earlier stages keep filling
//   any empty slots ahead of them, so req stays ready until the chain
//   is full.
`timescale 1ns / 1ps
`default_nettype none

module tea_block_cipher_core
	import tea_pkg::*;
#(
	parameter int ROUND_COUNT = TEA_ROUNDS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [TEA_KEY_IDX_W-1:0] cfg_idx,
	input  wire logic [31:0]              cfg_data,
	tea_req_if.sink                       req,
	tea_rsp_if.source                     rsp
);

	tea_key_t  key_q;
	tea_link_t link [ROUND_COUNT+1];
	logic      rdy  [ROUND_COUNT+1];

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[KEY_IDX_W0] <= KEY_RST_W0;
			key_q[KEY_IDX_W1] <= KEY_RST_W1;
			key_q[KEY_IDX_W2] <= KEY_RST_W2;
			key_q[KEY_IDX_W3] <= KEY_RST_W3;
		end else if (cfg_we) begin
			key_q[cfg_idx] <= cfg_data;
		end
	end

	// Chain entry
	assign link[0]   = {req.valid, req.req_type, req.block_first, req.block_second};
	assign req.ready = rdy[0];

	// Round cells
	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_cell
		tea_cell #(
			.ROUND_COUNT (ROUND_COUNT),
			.ROUND_IDX   (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key_q),
			.up_link  (link[i]),
			.up_ready (rdy[i]),
			.dn_link  (link[i+1]),
			.dn_ready (rdy[i+1])
		);
	end

	// Chain exit
	assign rsp.valid           = link[ROUND_COUNT].valid;
	assign rsp.out_first       = link[ROUND_COUNT].data.a;
	assign rsp.out_second      = link[ROUND_COUNT].data.b;
	assign rdy[ROUND_COUNT]    = rsp.ready;

endmodule

`default_nettype wire
